// File: rtl/prrt_pkg.sv
`default_nettype none
package prrt_pkg;

	// Field widths
	localparam int KIND_W  = 2;
	localparam int QID_W   = 16;
	localparam int MTYPE_W = 8;
	localparam int NN_W    = 8;
	localparam int EV_W    = 3;
	localparam int NAMES_W = 4;
	localparam int SENDS_W = 5;
	localparam int CFG_W   = 4;

	// APB
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// Register indexes (paddr[2])
	localparam logic REG_RETRY_LIMIT = 1'b0;
	localparam logic REG_MAX_NAMES   = 1'b1;

	localparam logic [CFG_W-1:0] RETRY_LIMIT_RST = 4'd3;
	localparam logic [CFG_W-1:0] MAX_NAMES_RST   = 4'd8;

	// Input kinds
	localparam logic [KIND_W-1:0] KIND_REQUEST  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RESPONSE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TIMEOUT  = 2'd2;

	// Only this message type is a response
	localparam logic [MTYPE_W-1:0] MTYPE_RESPONSE = 8'd1;

	localparam logic [SENDS_W-1:0] SENDS_SAT = 5'd31;

	// Event codes
	typedef enum logic [EV_W-1:0] {
		EV_SENT     = 3'd0,
		EV_RESENT   = 3'd1,
		EV_FAILED   = 3'd2,
		EV_ANSWERED = 3'd3,
		EV_BADCOUNT = 3'd4,
		EV_FULL     = 3'd5,
		EV_IGNORED  = 3'd6
	} event_t;

	// One table entry
	typedef struct packed {
		logic [QID_W-1:0]   id;
		logic [SENDS_W-1:0] sends;
		logic [NAMES_W-1:0] names;
	} entry_t;

	// Per-cell control
	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

	// Configuration values
	typedef struct packed {
		logic [CFG_W-1:0] retry_limit;
		logic [CFG_W-1:0] max_names;
	} cfg_t;

	// One result transaction
	typedef struct packed {
		logic [EV_W-1:0]    event_res;
		logic [QID_W-1:0]   result_id;
		logic [NAMES_W-1:0] result_names;
		logic [SENDS_W-1:0] sends_done;
		logic               last;
	} result_t;

endpackage
`default_nettype wire

// File: rtl/prrt_in_if.sv
`default_nettype none
interface prrt_in_if import prrt_pkg::*;;
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [QID_W-1:0]   resp_id;
	logic [MTYPE_W-1:0] msg_type;
	logic [NN_W-1:0]    num_names;

	modport source (output valid, kind, resp_id, msg_type, num_names, input ready);
	modport sink (input valid, kind, resp_id, msg_type, num_names, output ready);
endinterface
`default_nettype wire

// File: rtl/prrt_out_if.sv
`default_nettype none
interface prrt_out_if import prrt_pkg::*;;
	logic               valid;
	logic               ready;
	logic [EV_W-1:0]    event_res;
	logic [QID_W-1:0]   result_id;
	logic [NAMES_W-1:0] result_names;
	logic [SENDS_W-1:0] sends_done;
	logic               last;

	modport source (output valid, event_res, result_id, result_names, sends_done, last,
		input ready);
	modport sink (input valid, event_res, result_id, result_names, sends_done, last,
		output ready);
endinterface
`default_nettype wire

// File: rtl/prrt_regs.sv
`default_nettype none
module prrt_regs import prrt_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output      logic [APB_DW-1:0] prdata,
	output      logic              pready,
	output      cfg_t              cfg
);
	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// Register writes, decoded on the word address bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.retry_limit <= RETRY_LIMIT_RST;
			cfg_q.max_names   <= MAX_NAMES_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_RETRY_LIMIT: cfg_q.retry_limit <= pwdata[CFG_W-1:0];
				REG_MAX_NAMES:   cfg_q.max_names   <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_RETRY_LIMIT: prdata[CFG_W-1:0] = cfg_q.retry_limit;
			REG_MAX_NAMES:   prdata[CFG_W-1:0] = cfg_q.max_names;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// File: rtl/prrt_cell.sv
`default_nettype none
module prrt_cell import prrt_pkg::*; (
	input  wire logic      clk,
	input  wire cell_ctl_t ctl,
	input  wire entry_t    right,
	input  wire entry_t    load_data,
	output      entry_t    entry
);
	entry_t entry_q;

	assign entry = entry_q;

	// Load wins over shift; otherwise take the right neighbor or hold
	always_ff @(posedge clk) begin
		priority if (ctl.load) begin
			entry_q <= load_data;
		end else if (ctl.shift) begin
			entry_q <= right;
		end else begin
			entry_q <= entry_q;
		end
	end
endmodule
`default_nettype wire

// File: rtl/pending_request_retry_tracker_top.sv
`default_nettype none
// Outstanding request table with retransmit. Entries sit in a row of cells in
// insertion order with the oldest in cell 0. A new request, a response of
// another message type, an unused kind or a response to an empty table is
// accepted and then gives one result. A timeout tick or a response to a
// non-empty table walks the table through cell 0, one entry per cycle while
// the row shifts toward it and kept entries re-enter at the tail; a timeout
// tick on an empty table gives no result. Backpressure on the result channel
// stalls the walk. Table contents are not cleared at reset; only the fill
// count is.
module pending_request_retry_tracker_top import prrt_pkg::*; #(
	parameter int TABLE_DEPTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	prrt_in_if.sink                in_ch,
	prrt_out_if.source             out_ch,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output      logic [APB_DW-1:0] prdata,
	output      logic              pready
);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_ONE  = 3'b010,
		ST_WALK = 3'b100
	} state_t;

	cfg_t cfg;

	prrt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	state_t             state_q;
	logic [CNT_W-1:0]   len_q;
	logic [CNT_W-1:0]   steps_q;
	logic [QID_W-1:0]   id_q;
	logic [QID_W-1:0]   qid_q;
	logic               tmo_q;
	logic               found_q;
	result_t            pend_q;
	result_t            pend_next;
	result_t            out_q;
	logic               out_valid_q;

	entry_t             cell_out [TABLE_DEPTH];
	entry_t             load_data;
	logic               shift_en;
	logic               load_en;
	logic [CNT_W-1:0]   load_pos;

	logic               accept;
	logic               out_free;
	logic               emit;
	result_t            emit_res;
	logic               advance;

	logic [QID_W-1:0]   id_next;
	logic               bad_count;
	logic               full;
	entry_t             head;
	logic [SENDS_W-1:0] sends_inc;
	logic               head_match;
	logic               keep;
	logic               last_step;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;

	assign id_next   = id_q + QID_W'(1);
	assign bad_count = (in_ch.num_names == '0) ||
		(in_ch.num_names > NN_W'(cfg.max_names));
	assign full      = (len_q >= CNT_W'(TABLE_DEPTH));

	assign head       = cell_out[0];
	assign sends_inc  = (head.sends != SENDS_SAT) ? head.sends + SENDS_W'(1) : head.sends;
	assign head_match = !found_q && (head.id == qid_q);
	assign last_step  = (steps_q == CNT_W'(1));
	assign keep       = tmo_q ? (head.sends <= SENDS_W'(cfg.retry_limit)) : !head_match;

	// Walk step: what the head entry produces
	always_comb begin
		emit_res = '0;
		emit     = 1'b0;
		unique case (state_q)
			ST_ONE: begin
				emit     = 1'b1;
				emit_res = pend_q;
			end
			ST_WALK: begin
				if (tmo_q) begin
					emit                   = 1'b1;
					emit_res.event_res     = keep ? EV_RESENT : EV_FAILED;
					emit_res.result_id     = head.id;
					emit_res.result_names  = head.names;
					emit_res.sends_done    = keep ? sends_inc : head.sends;
					emit_res.last          = last_step;
				end else if (head_match) begin
					emit                   = 1'b1;
					emit_res.event_res     = EV_ANSWERED;
					emit_res.result_id     = qid_q;
					emit_res.result_names  = head.names;
					emit_res.sends_done    = head.sends;
					emit_res.last          = 1'b1;
				end else if (!found_q && last_step) begin
					emit                   = 1'b1;
					emit_res.event_res     = EV_IGNORED;
					emit_res.result_id     = qid_q;
					emit_res.last          = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign advance = (state_q == ST_WALK) && (!emit || out_free);

	// Cell row control: append on a request, rotate on a walk step
	always_comb begin
		shift_en  = 1'b0;
		load_en   = 1'b0;
		load_pos  = len_q;
		load_data = head;
		if (accept && (in_ch.kind == KIND_REQUEST) && !bad_count && !full) begin
			load_en         = 1'b1;
			load_data.id    = id_next;
			load_data.sends = SENDS_W'(1);
			load_data.names = in_ch.num_names[NAMES_W-1:0];
		end else if (advance) begin
			shift_en        = 1'b1;
			load_en         = keep;
			load_pos        = len_q - CNT_W'(1);
			load_data.sends = tmo_q ? sends_inc : head.sends;
		end
	end

	// Row of entry cells
	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		cell_ctl_t ctl;
		entry_t    right;
		assign ctl.shift = shift_en;
		assign ctl.load  = load_en && (load_pos == CNT_W'(k));
		if (k == TABLE_DEPTH - 1) begin : g_tail
			assign right = cell_out[k];
		end else begin : g_mid
			assign right = cell_out[k+1];
		end
		prrt_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.right     (right),
			.load_data (load_data),
			.entry     (cell_out[k])
		);
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= '0;
			steps_q <= '0;
			id_q    <= '0;
			found_q <= 1'b0;
			tmo_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						found_q <= 1'b0;
						steps_q <= len_q;
						tmo_q   <= (in_ch.kind == KIND_TIMEOUT);
						priority if (in_ch.kind == KIND_REQUEST) begin
							id_q    <= id_next;
							state_q <= ST_ONE;
							if (!bad_count && !full) begin
								len_q <= len_q + CNT_W'(1);
							end
						end else if ((in_ch.kind == KIND_RESPONSE) &&
							(in_ch.msg_type == MTYPE_RESPONSE)) begin
							state_q <= (len_q == '0) ? ST_ONE : ST_WALK;
						end else if (in_ch.kind == KIND_TIMEOUT) begin
							state_q <= (len_q == '0) ? ST_IDLE : ST_WALK;
						end else begin
							state_q <= ST_ONE;
						end
					end
				end
				ST_ONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WALK: begin
					if (advance) begin
						steps_q <= steps_q - CNT_W'(1);
						if (!keep) begin
							len_q <= len_q - CNT_W'(1);
						end
						if (!tmo_q && head_match) begin
							found_q <= 1'b1;
						end
						if (last_step) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Single-result payload for the accepted transaction
	always_comb begin
		pend_next      = '0;
		pend_next.last = 1'b1;
		if (in_ch.kind == KIND_REQUEST) begin
			pend_next.result_id = id_next;
			priority if (bad_count) begin
				pend_next.event_res = EV_BADCOUNT;
			end else if (full) begin
				pend_next.event_res    = EV_FULL;
				pend_next.result_names = in_ch.num_names[NAMES_W-1:0];
			end else begin
				pend_next.event_res    = EV_SENT;
				pend_next.result_names = in_ch.num_names[NAMES_W-1:0];
				pend_next.sends_done   = SENDS_W'(1);
			end
		end else begin
			pend_next.event_res = EV_IGNORED;
			pend_next.result_id = in_ch.resp_id;
		end
	end

	// Single-result payload and response id, captured at accept
	always_ff @(posedge clk) begin
		if (accept) begin
			qid_q  <= in_ch.resp_id;
			pend_q <= pend_next;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && out_free) begin
			out_q <= emit_res;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.event_res    = out_q.event_res;
	assign out_ch.result_id    = out_q.result_id;
	assign out_ch.result_names = out_q.result_names;
	assign out_ch.sends_done   = out_q.sends_done;
	assign out_ch.last         = out_q.last;

	// Checks
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CNT_W'(TABLE_DEPTH))
		else $error("table fill count above depth");

	a_walk_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (steps_q != '0) && (steps_q <= len_q))
		else $error("walk step count out of range");

	a_id_advance: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (in_ch.kind == KIND_REQUEST) |=> id_q == $past(id_next))
		else $error("id counter did not advance on a request");

	a_walk_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |=> len_q <= $past(len_q))
		else $error("table grew during a walk");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q && $stable(out_q))
		else $error("pending result lost");
endmodule
`default_nettype wire

// File: verif/pending_request_retry_tracker_top_tb.sv
`timescale 1ns / 1ps

module pending_request_retry_tracker_top_tb;
	import prrt_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = TABLE_DEPTH + 4;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	// Mirror of the request table; predicts the events each accepted transaction causes
	class retry_table_scoreboard;
		result_t            expected_events[$];
		logic [QID_W-1:0]   ent_id[TABLE_DEPTH];
		logic [SENDS_W-1:0] ent_sends[TABLE_DEPTH];
		logic [NAMES_W-1:0] ent_names[TABLE_DEPTH];
		int                 fill;
		logic [QID_W-1:0]   id_ctr;
		logic [CFG_W-1:0]   retry_lim;
		logic [CFG_W-1:0]   names_lim;
		int                 errors;

		function new();
			fill = 0;
			id_ctr = '0;
			retry_lim = RETRY_LIMIT_RST;
			names_lim = MAX_NAMES_RST;
			errors = 0;
		endfunction

		function void set_config(logic idx, logic [CFG_W-1:0] value);
			if (idx == REG_RETRY_LIMIT) retry_lim = value;
			else names_lim = value;
		endfunction

		function void check_register(logic idx, logic [APB_DW-1:0] got);
			logic [APB_DW-1:0] want;
			want = (idx == REG_RETRY_LIMIT) ? APB_DW'(retry_lim) : APB_DW'(names_lim);
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("register %0d readback: expected %0d, got %0d", idx, want, got);
			end
		endfunction

		function result_t pack_event(event_t ev, logic [QID_W-1:0] id,
				logic [NAMES_W-1:0] names, logic [SENDS_W-1:0] sends);
			result_t r;
			r.event_res = ev;
			r.result_id = id;
			r.result_names = names;
			r.sends_done = sends;
			r.last = 1'b0;
			return r;
		endfunction

		function string describe(result_t r);
			return $sformatf("ev=%0d id=%h names=%0d sends=%0d last=%0d",
				r.event_res, r.result_id, r.result_names, r.sends_done, r.last);
		endfunction

		// Update the table for one accepted transaction and queue its events
		function void track_item(logic [KIND_W-1:0] kind, logic [QID_W-1:0] qid,
				logic [MTYPE_W-1:0] mtype, logic [NN_W-1:0] nn);
			result_t            outs[$];
			logic [SENDS_W-1:0] s;
			int                 i;
			int                 w;
			int                 keep;
			bit                 hit;
			if (kind == KIND_REQUEST) begin
				// ID advances even when the request is rejected
				id_ctr = id_ctr + 1'b1;
				if (nn == 0 || nn > names_lim) begin
					outs.push_back(pack_event(EV_BADCOUNT, id_ctr, '0, '0));
				end else if (fill >= TABLE_DEPTH) begin
					outs.push_back(pack_event(EV_FULL, id_ctr, nn[NAMES_W-1:0], '0));
				end else begin
					ent_id[fill] = id_ctr;
					ent_names[fill] = nn[NAMES_W-1:0];
					ent_sends[fill] = 5'd1;
					fill++;
					outs.push_back(pack_event(EV_SENT, id_ctr, nn[NAMES_W-1:0], 5'd1));
				end
			end else if (kind == KIND_RESPONSE && mtype == MTYPE_RESPONSE) begin
				// oldest matching entry is answered and removed
				hit = 1'b0;
				for (i = 0; i < fill && !hit; i++) begin
					if (ent_id[i] == qid) begin
						outs.push_back(pack_event(EV_ANSWERED, qid, ent_names[i], ent_sends[i]));
						for (w = i; w + 1 < fill; w++) begin
							ent_id[w] = ent_id[w+1];
							ent_sends[w] = ent_sends[w+1];
							ent_names[w] = ent_names[w+1];
						end
						fill--;
						hit = 1'b1;
					end
				end
				if (!hit) outs.push_back(pack_event(EV_IGNORED, qid, '0, '0));
			end else if (kind == KIND_TIMEOUT) begin
				// walk in order: resend while at or under the retry limit, else drop
				keep = 0;
				for (i = 0; i < fill; i++) begin
					s = ent_sends[i];
					if (s <= retry_lim) begin
						if (s != SENDS_SAT) s = s + 1'b1;
						ent_id[keep] = ent_id[i];
						ent_names[keep] = ent_names[i];
						ent_sends[keep] = s;
						keep++;
						outs.push_back(pack_event(EV_RESENT, ent_id[i], ent_names[i], s));
					end else begin
						outs.push_back(pack_event(EV_FAILED, ent_id[i], ent_names[i], s));
					end
				end
				fill = keep;
			end else begin
				outs.push_back(pack_event(EV_IGNORED, qid, '0, '0));
			end
			if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
			foreach (outs[k]) expected_events.push_back(outs[k]);
		endfunction

		function void check_event(result_t got);
			result_t want;
			if (expected_events.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result: %s", describe(got));
			end else begin
				want = expected_events.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("result mismatch: expected %s, got %s", describe(want),
							describe(got));
				end
			end
		endfunction

		function int pending();
			return expected_events.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	bit idle_on = 1'b0;
	int hold_len = 0;

	retry_table_scoreboard sb = new();

	prrt_in_if  in_ch();
	prrt_out_if out_ch();

	pending_request_retry_tracker_top #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Monitor: note accepted requests, check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				sb.track_item(in_ch.kind, in_ch.resp_id, in_ch.msg_type, in_ch.num_names);
			if (out_ch.valid && out_ch.ready)
				sb.check_event({out_ch.event_res, out_ch.result_id, out_ch.result_names,
					out_ch.sends_done, out_ch.last});
		end
	end

	// Result sink: random stall bursts, plus a long hold on request
	initial begin : result_sink
		int n;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				n = hold_len;
				hold_len = 0;
				out_ch.ready <= 1'b0;
				repeat (n - 1) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 6) - 1) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: ends the run when nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
					(psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	task automatic send_item(input logic [KIND_W-1:0] kind, input logic [QID_W-1:0] qid,
			input logic [MTYPE_W-1:0] mtype, input logic [NN_W-1:0] nn);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= kind;
		in_ch.resp_id <= qid;
		in_ch.msg_type <= mtype;
		in_ch.num_names <= nn;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Stop offering, drain every expected result, then let a silent walk finish
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input bit wr, input logic idx, input logic [APB_DW-1:0] wdata);
		logic [APB_DW-1:0] rdata;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (wr) sb.set_config(idx, wdata[CFG_W-1:0]);
		else sb.check_register(idx, rdata);
		@(posedge clk);
	endtask

	task automatic set_limits(input logic [CFG_W-1:0] retry, input logic [CFG_W-1:0] names);
		wait_idle();
		apb_access(1'b1, REG_RETRY_LIMIT, APB_DW'(retry));
		apb_access(1'b1, REG_MAX_NAMES, APB_DW'(names));
		apb_access(1'b0, REG_RETRY_LIMIT, '0);
		apb_access(1'b0, REG_MAX_NAMES, '0);
	endtask

	// Mostly well-formed traffic: valid requests, answers to live IDs, timeouts
	task automatic run_random(input int count);
		logic [KIND_W-1:0]  kind;
		logic [QID_W-1:0]   qid;
		logic [MTYPE_W-1:0] mtype;
		logic [NN_W-1:0]    nn;
		int                 pick;
		int                 sub;
		repeat (count) begin
			qid = QID_W'($urandom);
			mtype = MTYPE_W'($urandom);
			nn = NN_W'($urandom);
			pick = $urandom_range(0, 99);
			sub = $urandom_range(0, 99);
			if (pick < 45) begin
				kind = KIND_REQUEST;
				if (sub < 75) nn = NN_W'($urandom_range(1, sb.names_lim));
				else if (sub < 85) nn = '0;
			end else if (pick < 70) begin
				kind = KIND_RESPONSE;
				if (sub < 70 && sb.fill > 0) qid = sb.ent_id[$urandom_range(0, sb.fill - 1)];
				if (sub < 85) mtype = MTYPE_RESPONSE;
			end else if (pick < 95) begin
				kind = KIND_TIMEOUT;
			end else begin
				kind = KIND_UNUSED;
			end
			send_item(kind, qid, mtype, nn);
		end
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.kind <= KIND_REQUEST;
		in_ch.resp_id <= '0;
		in_ch.msg_type <= '0;
		in_ch.num_names <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values of both registers
		apb_access(1'b0, REG_RETRY_LIMIT, '0);
		apb_access(1'b0, REG_MAX_NAMES, '0);

		// Directed: empty table, rejects, ignored responses, answer, retry to failure
		send_item(KIND_TIMEOUT, 16'h0000, 8'h00, 8'h00);
		send_item(KIND_RESPONSE, 16'h0000, MTYPE_RESPONSE, 8'h00);
		send_item(KIND_UNUSED, 16'hFFFF, 8'hFF, 8'hFF);
		send_item(KIND_REQUEST, 16'h0000, 8'h00, 8'd0);
		send_item(KIND_REQUEST, 16'h0000, 8'h00, 8'd9);
		send_item(KIND_REQUEST, 16'hFFFF, 8'hFF, 8'd255);
		send_item(KIND_REQUEST, 16'h0000, 8'h00, 8'd1);
		send_item(KIND_REQUEST, 16'h0000, 8'h00, 8'd8);
		send_item(KIND_REQUEST, 16'h0000, 8'h00, 8'd3);
		send_item(KIND_RESPONSE, 16'd5, 8'h00, 8'h00);
		send_item(KIND_RESPONSE, 16'd5, 8'hFF, 8'h00);
		send_item(KIND_RESPONSE, 16'd5, MTYPE_RESPONSE, 8'h00);
		send_item(KIND_RESPONSE, 16'd5, MTYPE_RESPONSE, 8'h00);
		repeat (4) send_item(KIND_TIMEOUT, 16'hA5A5, 8'h5A, 8'hC3);
		send_item(KIND_TIMEOUT, 16'h0000, 8'h00, 8'h00);
		send_item(KIND_RESPONSE, 16'd4, MTYPE_RESPONSE, 8'h00);

		// Long result stall while requests keep coming: table fills, input backs up
		set_limits(4'd15, 4'd8);
		idle_on = 1'b1;
		hold_len = 150;
		repeat (20) send_item(KIND_REQUEST, QID_W'($urandom), MTYPE_W'($urandom),
			NN_W'($urandom_range(1, 8)));
		repeat (2) send_item(KIND_TIMEOUT, QID_W'($urandom), MTYPE_W'($urandom),
			NN_W'($urandom));
		run_random(52);

		set_limits(4'd0, 4'd1);
		run_random(52);

		set_limits(4'd1, 4'd4);
		idle_on = 1'b0;
		run_random(52);

		set_limits(4'd7, 4'd2);
		idle_on = 1'b1;
		run_random(52);

		set_limits(4'd2, 4'd5);
		idle_on = 1'b1;
		run_random(52);

		// last stretch runs with no idling on either side
		set_limits(4'd3, 4'd3);
		idle_on = 1'b0;
		run_random(70);

		wait_idle();
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: filelist.f
rtl/prrt_pkg.sv
rtl/prrt_in_if.sv
rtl/prrt_out_if.sv
rtl/prrt_regs.sv
rtl/prrt_cell.sv
rtl/pending_request_retry_tracker_top.sv
verif/pending_request_retry_tracker_top_tb.sv
